// ===== sv/hcpm_pkg.sv =====
// Package for the hysteresis crossing period meter.
// Holds field widths, register indexes, reset values and the
// controller/datapath command and status types. No dependencies.
package hcpm_pkg;

  localparam int SampleW = 8;
  localparam int PeriodW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 8;

  localparam logic [PeriodW-1:0] CountMax = 8'hFF;

  localparam logic [CfgIdxW-1:0] RegHighThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLowThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOutputMode = 2'd2;

  localparam logic [SampleW-1:0] HighThresholdRst = 8'd252;
  localparam logic [SampleW-1:0] LowThresholdRst = 8'd3;

  // One quotient bit per divider step.
  localparam int DivSteps = PeriodW;
  localparam int DivCntW = $clog2(DivSteps);

  typedef struct packed {
    logic step;      // an input transfer happens at this edge
    logic div_step;  // run one divider iteration
    logic div_last;  // this iteration is the final one
  } hcpm_cmd_t;

  typedef struct packed {
    logic need_div;  // the offered sample causes a crossing in mode 1
    logic out_free;  // the output register can take a result at this edge
  } hcpm_status_t;

endpackage

// ===== sv/hcpm_if.sv =====
// Valid/ready stream interfaces for the sample input and period output.
// Depends on hcpm_pkg for the payload widths.
interface hcpm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [hcpm_pkg::SampleW-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface hcpm_period_if;
  logic                         valid;
  logic                         ready;
  logic [hcpm_pkg::PeriodW-1:0] period_value;

  modport source(output valid, output period_value, input ready);
  modport sink(input valid, input period_value, output ready);
endinterface

// ===== sv/hcpm_ctrl.sv =====
// Controller of the period meter: accepts samples and sequences the
// iterative divider. Depends on hcpm_pkg for the command and status types.
module hcpm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hcpm_pkg::hcpm_status_t status_i,
  output hcpm_pkg::hcpm_cmd_t    cmd_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_DIV  = 1'b1;

  logic [0:0]                   state_q, state_d;
  logic [hcpm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         accept;
  logic                         last;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == hcpm_pkg::DivCntW'(hcpm_pkg::DivSteps - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.step = accept;
        if (accept && status_i.need_div) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = last;
        cnt_d          = cnt_q + 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/hcpm_dp.sv =====
// Datapath of the period meter: configuration registers, hysteresis level,
// sample counter, restoring divider and output register. Depends on hcpm_pkg.
module hcpm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcpm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [hcpm_pkg::SampleW-1:0]  sample_i,
  input  hcpm_pkg::hcpm_cmd_t           cmd_i,
  output hcpm_pkg::hcpm_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hcpm_pkg::PeriodW-1:0]  period_value_o
);

  localparam int W = hcpm_pkg::PeriodW;

  logic [hcpm_pkg::SampleW-1:0] high_q, low_q;
  logic                         mode_q;
  logic                         level_low_q, level_low_d;
  logic [W-1:0]                 count_q, count_d;
  logic [W-1:0]                 rem_q, rem_d;
  logic [W-1:0]                 quo_q, quo_d;
  logic [W-1:0]                 divisor_q, divisor_d;
  logic                         out_valid_q, out_valid_d;
  logic [W-1:0]                 out_data_q, out_data_d;

  logic         lvl_mid, lvl_new, change;
  logic [W-1:0] n_eff;
  logic [W:0]   n_plus1;
  logic [W-1:0] dividend;
  logic [W:0]   trial, trial_sub;
  logic [W-1:0] rem_next, quo_next;

  // The low check runs first; a sample meeting both thresholds can
  // take a high level low and straight back high.
  always_comb begin
    lvl_mid = level_low_q;
    if (!level_low_q && (sample_i <= low_q)) begin
      lvl_mid = 1'b1;
    end
    lvl_new = lvl_mid;
    if (lvl_mid && (sample_i >= high_q)) begin
      lvl_new = 1'b0;
    end
    change = (lvl_new != level_low_q);
  end

  assign status_o.need_div = change && mode_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign n_eff    = (count_q == '0) ? W'(1) : count_q;
  assign n_plus1  = {1'b0, n_eff} + (W+1)'(1);
  assign dividend = hcpm_pkg::CountMax - n_plus1[W:1];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial     = {rem_q, quo_q[W-1]};
    trial_sub = trial - {1'b0, divisor_q};
    if (!trial_sub[W]) begin
      rem_next = trial_sub[W-1:0];
      quo_next = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_next = trial[W-1:0];
      quo_next = {quo_q[W-2:0], 1'b0};
    end
  end

  always_comb begin
    level_low_d = level_low_q;
    count_d     = count_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    divisor_d   = divisor_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.step) begin
      level_low_d = lvl_new;
      if (change) begin
        count_d = W'(1);
        if (mode_q) begin
          rem_d     = '0;
          quo_d     = dividend;
          divisor_d = n_eff;
        end else begin
          out_data_d  = count_q;
          out_valid_d = 1'b1;
        end
      end else if (count_q != hcpm_pkg::CountMax) begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.div_step) begin
      rem_d = rem_next;
      quo_d = quo_next;
      if (cmd_i.div_last) begin
        out_data_d  = quo_next + 1'b1;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q      <= hcpm_pkg::HighThresholdRst;
      low_q       <= hcpm_pkg::LowThresholdRst;
      mode_q      <= 1'b0;
      level_low_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hcpm_pkg::RegHighThreshold: high_q <= cfg_data_i[hcpm_pkg::SampleW-1:0];
          hcpm_pkg::RegLowThreshold:  low_q  <= cfg_data_i[hcpm_pkg::SampleW-1:0];
          hcpm_pkg::RegOutputMode:    mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      level_low_q <= level_low_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    divisor_q  <= divisor_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign period_value_o = out_data_q;

endmodule

// ===== sv/hysteresis_crossing_period_meter_top.sv =====
// Top level of the hysteresis crossing period meter.
// Instantiates hcpm_ctrl and hcpm_dp; depends on hcpm_pkg and hcpm_if.
//
// Each accepted 8-bit sample updates a Schmitt-trigger level (starts high)
// and a saturating sample counter; a level change emits one result, the
// count since the last change (mode 0) or the frequency factor
// ((255-(n+1)/2)/n)+1 (mode 1). A sample that causes no result, or a
// crossing in mode 0, needs only its transfer. A crossing in mode 1 is followed
// by the run of the one-bit-per-cycle restoring divider, during which no
// sample is accepted. A finished result sits in an output register; while it
// waits there no sample is accepted, unless the result is taken in the same
// cycle. Configuration writes must only be issued while no result is pending
// or in progress.
module hysteresis_crossing_period_meter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcpm_pkg::CfgDataW-1:0] cfg_data_i,
  hcpm_sample_if.sink                   in_if,
  hcpm_period_if.source                 out_if
);

  hcpm_pkg::hcpm_cmd_t    cmd;
  hcpm_pkg::hcpm_status_t status;

  hcpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcpm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (in_if.sample),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .period_value_o (out_if.period_value)
  );

endmodule

// ===== test/hcpm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the hysteresis crossing period meter: follows the register
// port and both streams, predicts every period result and checks it.
// Depends on hcpm_pkg and the stream interfaces of hcpm_if.
module hcpm_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hcpm_pkg::CfgDataW-1:0] cfg_data_i,
  hcpm_sample_if                        sample_ch,
  hcpm_period_if                        period_ch,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  logic [hcpm_pkg::SampleW-1:0] high_th;
  logic [hcpm_pkg::SampleW-1:0] low_th;
  logic                         factor_mode;
  logic                         level_low;
  logic [hcpm_pkg::PeriodW-1:0] sample_count;

  logic [hcpm_pkg::PeriodW-1:0] period_expected_q[$];
  logic [hcpm_pkg::PeriodW-1:0] want;
  int                           fails = 0;
  int                           checked = 0;

  function automatic logic [hcpm_pkg::PeriodW-1:0] factor_of(
      logic [hcpm_pkg::PeriodW-1:0] n);
    int d;
    // A crossing on the very first sample has a count of zero; it is treated as one.
    d = (n == '0) ? 1 : int'(n);
    return hcpm_pkg::PeriodW'((int'(hcpm_pkg::CountMax) - (d + 1) / 2) / d + 1);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic predict_sample(logic [hcpm_pkg::SampleW-1:0] s);
    logic lvl;
    lvl = level_low;
    if (!lvl && s <= low_th) lvl = 1'b1;
    if (lvl && s >= high_th) lvl = 1'b0;
    if (lvl != level_low) begin
      period_expected_q.push_back(factor_mode ? factor_of(sample_count) : sample_count);
      sample_count = '0;
      level_low = lvl;
    end
    if (sample_count != hcpm_pkg::CountMax) sample_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_th = hcpm_pkg::HighThresholdRst;
      low_th = hcpm_pkg::LowThresholdRst;
      factor_mode = 1'b0;
      level_low = 1'b0;
      sample_count = '0;
      period_expected_q.delete();
    end else begin
      if (period_ch.valid && period_ch.ready) begin
        if (period_expected_q.size() == 0) begin
          report_mismatch($sformatf("period %0d with no result expected",
                                    period_ch.period_value));
        end else begin
          want = period_expected_q.pop_front();
          checked++;
          if (period_ch.period_value !== want)
            report_mismatch($sformatf("period_value %0d, expected %0d",
                                      period_ch.period_value, want));
        end
      end
      if (sample_ch.valid && sample_ch.ready) predict_sample(sample_ch.sample);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hcpm_pkg::RegHighThreshold: high_th = cfg_data_i;
          hcpm_pkg::RegLowThreshold: low_th = cfg_data_i;
          hcpm_pkg::RegOutputMode: factor_mode = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o <= period_expected_q.size();
    checked_o <= checked;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the hysteresis crossing period meter: clock, reset,
// register writes and stream traffic; hcpm_checker predicts and compares.
// Depends on hcpm_pkg, hcpm_if, the block's RTL and hcpm_checker.
module testbench;

  localparam int IdleLimit = 1000;
  localparam int SettleCycles = 12;
  localparam int HoldOffCycles = 60;
  localparam logic [hcpm_pkg::CfgIdxW-1:0] RegOutOfRange = 2'd3;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [hcpm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [hcpm_pkg::CfgDataW-1:0] cfg_data_i;

  hcpm_sample_if sample_ch();
  hcpm_period_if period_ch();

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int settings_run = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  bit hold_off_due = 1'b0;
  bit hold_off_taken = 1'b0;

  logic [hcpm_pkg::SampleW-1:0] cur_high;
  logic [hcpm_pkg::SampleW-1:0] cur_low;
  logic [hcpm_pkg::SampleW-1:0] sample_q[$];

  hysteresis_crossing_period_meter_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_if (sample_ch),
    .out_if(period_ch)
  );

  hcpm_checker period_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .sample_ch,
    .period_ch,
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic write_reg(input logic [hcpm_pkg::CfgIdxW-1:0] idx,
                           input logic [hcpm_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits until every expected period has been taken, then lets a divide that
  // may still be running finish before the registers are touched.
  task automatic settle();
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_samples();
    int burst;
    int gap;
    burst = 0;
    while (sample_q.size() > 0) begin
      @(negedge clk_i);
      if (burst == 0) begin
        burst = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(12, 1);
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
        if (gap > 0) begin
          sample_ch.valid = 1'b0;
          sample_ch.sample = hcpm_pkg::SampleW'($urandom);
          repeat (gap) @(negedge clk_i);
        end
      end
      sample_ch.valid = 1'b1;
      sample_ch.sample = sample_q.pop_front();
      do @(posedge clk_i); while (!sample_ch.ready);
      burst--;
      items_sent++;
    end
    @(negedge clk_i);
    sample_ch.valid = 1'b0;
  endtask

  function automatic logic [hcpm_pkg::SampleW-1:0] pick_low();
    return hcpm_pkg::SampleW'($urandom_range(int'(cur_low), 0));
  endfunction

  function automatic logic [hcpm_pkg::SampleW-1:0] pick_high();
    return hcpm_pkg::SampleW'($urandom_range(255, int'(cur_high)));
  endfunction

  // Values that keep the present level where it is.
  function automatic logic [hcpm_pkg::SampleW-1:0] hold_low();
    if (cur_high == '0) return hcpm_pkg::SampleW'($urandom);
    return hcpm_pkg::SampleW'($urandom_range(int'(cur_high) - 1, 0));
  endfunction

  function automatic logic [hcpm_pkg::SampleW-1:0] hold_high();
    if (cur_low == '1) return hcpm_pkg::SampleW'($urandom);
    return hcpm_pkg::SampleW'($urandom_range(255, int'(cur_low) + 1));
  endfunction

  // Builds a square-ish wave around the thresholds with random run lengths,
  // mixed with short bursts of unshaped noise.
  task automatic make_waveform(input int n_items, input int sat_len);
    int run;
    int k;
    bit go_low;
    go_low = 1'b1;
    while (sample_q.size() < n_items) begin
      if ($urandom_range(6, 0) == 0) begin
        repeat ($urandom_range(4, 1)) sample_q.push_back(hcpm_pkg::SampleW'($urandom));
      end else begin
        run = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(8, 1);
        sample_q.push_back(go_low ? pick_low() : pick_high());
        for (k = 1; k < run; k++) sample_q.push_back(go_low ? hold_low() : hold_high());
        go_low = !go_low;
      end
    end
    if (sat_len > 0) begin
      sample_q.push_back(pick_low());
      for (k = 0; k < sat_len; k++) sample_q.push_back(hold_low());
      sample_q.push_back(pick_high());
    end
  endtask

  task automatic run_phase(input logic [hcpm_pkg::SampleW-1:0] hi,
                           input logic [hcpm_pkg::SampleW-1:0] lo,
                           input logic md, input int n_items, input bit long_hold,
                           input int sat_len);
    settle();
    write_reg(hcpm_pkg::RegHighThreshold, hi);
    write_reg(hcpm_pkg::RegLowThreshold, lo);
    write_reg(hcpm_pkg::RegOutputMode, {7'($urandom), md});
    cur_high = hi;
    cur_low = lo;
    settings_run++;
    make_waveform(n_items, sat_len);
    if (long_hold) hold_off_due = 1'b1;
    send_samples();
  endtask

  initial begin
    logic [hcpm_pkg::SampleW-1:0] lo;
    logic [hcpm_pkg::SampleW-1:0] hi;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = hcpm_pkg::RegHighThreshold;
    cfg_data_i = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Factor mode from reset, so the first sample crosses with a count of zero.
    write_reg(hcpm_pkg::RegHighThreshold, 8'd252);
    write_reg(hcpm_pkg::RegLowThreshold, 8'd3);
    write_reg(hcpm_pkg::RegOutputMode, 8'hFF);
    settings_run++;
    sample_q = '{8'd0, 8'd255, 8'd128, 8'd3, 8'd4, 8'd252, 8'd251, 8'd2, 8'd253, 8'd1,
                 8'd254};
    send_samples();

    // Overlapping thresholds: from a high level a sample in both bands changes nothing.
    settle();
    write_reg(hcpm_pkg::RegHighThreshold, 8'd100);
    write_reg(hcpm_pkg::RegLowThreshold, 8'd200);
    write_reg(hcpm_pkg::RegOutputMode, 8'hFE);
    write_reg(RegOutOfRange, hcpm_pkg::CfgDataW'($urandom));
    settings_run++;
    sample_q = '{8'd150, 8'd50, 8'd150, 8'd150, 8'd200, 8'd0, 8'd255, 8'd99, 8'd201};
    send_samples();

    run_phase(8'd252, 8'd3, 1'b0, 40, 1'b1, 0);
    run_phase(8'd255, 8'd0, 1'b1, 30, 1'b0, 0);
    run_phase(8'd0, 8'd255, 1'b0, 20, 1'b0, 0);
    lo = hcpm_pkg::SampleW'($urandom_range(200, 0));
    hi = hcpm_pkg::SampleW'($urandom_range(255, int'(lo) + 1));
    run_phase(hi, lo, 1'b1, 40, 1'b0, 0);
    hi = hcpm_pkg::SampleW'($urandom_range(200, 0));
    lo = hcpm_pkg::SampleW'($urandom_range(255, int'(hi)));
    run_phase(hi, lo, 1'b1, 30, 1'b0, 0);
    lo = hcpm_pkg::SampleW'($urandom_range(120, 0));
    hi = hcpm_pkg::SampleW'($urandom_range(255, int'(lo) + 1));
    run_phase(hi, lo, 1'b0, 20, 1'b0, 260);
    run_phase(8'd128, 8'd127, 1'b1, 40, 1'b0, 0);
    run_phase(hcpm_pkg::SampleW'($urandom), hcpm_pkg::SampleW'($urandom), 1'($urandom),
              40, 1'b0, 0);

    settle();
    @(negedge clk_i);
    $display("summary: %0d samples over %0d threshold and mode settings, %0d periods checked",
             items_sent, settings_run, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // The result side stalls on a rotating pattern of four ready styles, and once
  // holds off long enough for the block to back up onto its input.
  initial begin
    period_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_off_due && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        period_ch.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      case ((rx_cycle / 97) % 4)
        0: period_ch.ready = 1'b1;
        1: period_ch.ready = 1'($urandom_range(1, 0));
        2: period_ch.ready = (rx_cycle % 5) < 2;
        default: period_ch.ready = ($urandom_range(7, 0) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_ch.valid && sample_ch.ready) || (period_ch.valid && period_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
sv/hcpm_pkg.sv
sv/hcpm_if.sv
sv/hcpm_ctrl.sv
sv/hcpm_dp.sv
sv/hysteresis_crossing_period_meter_top.sv
test/hcpm_checker.sv
test/testbench.sv
